// File: sv/nibdtmf_pkg.sv
// Shared types, constants and table function for the ASCII nibble DTMF generator.
package nibdtmf_pkg;

   localparam int unsigned TONE_FS_HZ = 8000;

   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned LEN_W      = 16;
   localparam int unsigned AMP_W      = 14;
   localparam int unsigned MAG_W      = 15;
   localparam int unsigned SUM_W      = 17;
   localparam int unsigned PROD_W     = 32;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_NOTE  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAUSE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_AMP   = 2'd2;

   localparam logic [LEN_W-1:0] NOTE_RESET  = 16'd800;
   localparam logic [LEN_W-1:0] PAUSE_RESET = 16'd400;
   localparam logic [AMP_W-1:0] AMP_RESET   = 14'd10000;

   localparam int unsigned ROW_HZ [4] = '{697, 770, 852, 941};
   localparam int unsigned COL_HZ [4] = '{1209, 1336, 1477, 1633};

   // Keypad position of each nibble; E is star and F is hash.
   localparam logic [1:0] NIB_ROW [16] = '{
      2'd3, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2,
      2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd3};
   localparam logic [1:0] NIB_COL [16] = '{
      2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
      2'd1, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd0, 2'd2};

   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;
   localparam logic [63:0] HALF_Q30 = 64'd536870912;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic [CHAR_W-1:0]  character;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HIGH,
      ST_GAP_A,
      ST_LOW,
      ST_GAP_B
   } state_type;

   typedef struct packed {
      logic fire;
      logic tone;
      logic last;
   } seq_ctl_type;

   // Quarter-wave cosine magnitude, unsigned Q0.15, for entry m of a 2^addr_bits table.
   // Ten Taylor terms in Q30; evaluated at elaboration only.
   function automatic logic [MAG_W-1:0] quarter_mag(input int unsigned m,
                                                    input int unsigned addr_bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        mag;
      logic signed [63:0] sum;
      x    = (64'd2 * PI_Q30 * 64'(m)) >> addr_bits;
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      sum  = $signed(ONE_Q30);
      term = ((term * x2) >> 30) / 64'd2;   sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd12;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd30;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd56;  sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd90;  sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd132; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd182; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd240; sum = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd306; sum = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd380; sum = sum + $signed(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      mag = ($unsigned(sum) * 64'd32767 + HALF_Q30) >> 30;
      return mag[MAG_W-1:0];
   endfunction

endpackage

// File: sv/nibdtmf_seq.sv
// Tone sequencer: configuration registers, segment state, counters and phase accumulators.
module nibdtmf_seq
   import nibdtmf_pkg::*;
#(
   parameter int unsigned PHASE_BITS      = 24,
   parameter int unsigned TABLE_ADDR_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wen_i,
   input  logic [CSR_ADDR_W-1:0]      csr_addr_i,
   input  logic [CSR_DATA_W-1:0]      csr_wdata_i,
   input  logic                       accept_i,
   input  req_type                    req_i,
   output logic [AMP_W-1:0]           amp_o,
   output logic [TABLE_ADDR_BITS-1:0] row_idx_o,
   output logic [TABLE_ADDR_BITS-1:0] col_idx_o,
   output seq_ctl_type                ctl_o
);

   localparam logic [63:0] HALF_RATE = 64'(TONE_FS_HZ / 2);

   localparam logic [PHASE_BITS-1:0] ROW_INC [4] = '{
      PHASE_BITS'(((64'(ROW_HZ[0]) << PHASE_BITS) + HALF_RATE) / 64'(TONE_FS_HZ)),
      PHASE_BITS'(((64'(ROW_HZ[1]) << PHASE_BITS) + HALF_RATE) / 64'(TONE_FS_HZ)),
      PHASE_BITS'(((64'(ROW_HZ[2]) << PHASE_BITS) + HALF_RATE) / 64'(TONE_FS_HZ)),
      PHASE_BITS'(((64'(ROW_HZ[3]) << PHASE_BITS) + HALF_RATE) / 64'(TONE_FS_HZ))};
   localparam logic [PHASE_BITS-1:0] COL_INC [4] = '{
      PHASE_BITS'(((64'(COL_HZ[0]) << PHASE_BITS) + HALF_RATE) / 64'(TONE_FS_HZ)),
      PHASE_BITS'(((64'(COL_HZ[1]) << PHASE_BITS) + HALF_RATE) / 64'(TONE_FS_HZ)),
      PHASE_BITS'(((64'(COL_HZ[2]) << PHASE_BITS) + HALF_RATE) / 64'(TONE_FS_HZ)),
      PHASE_BITS'(((64'(COL_HZ[3]) << PHASE_BITS) + HALF_RATE) / 64'(TONE_FS_HZ))};

   logic [LEN_W-1:0]      note_ff;
   logic [LEN_W-1:0]      pause_ff;
   logic [AMP_W-1:0]      amp_ff;

   state_type             state_ff,     state_in;
   logic [CHAR_W-1:0]     held_ff,      held_in;
   logic [LEN_W-1:0]      count_ff,     count_in;
   logic [PHASE_BITS-1:0] row_phase_ff, row_phase_in;
   logic [PHASE_BITS-1:0] col_phase_ff, col_phase_in;

   logic                  idle;
   logic                  load;
   logic                  tick_busy;
   logic                  tone;
   logic                  gap;
   logic                  pause_zero;
   logic [LEN_W-1:0]      seg_len;
   logic                  seg_end;
   logic [3:0]            nib;
   logic [PHASE_BITS-1:0] row_inc;
   logic [PHASE_BITS-1:0] col_inc;

   assign idle       = (state_ff == ST_IDLE);
   assign load       = accept_i && (req_i.operation == OP_LOAD) && idle;
   assign tick_busy  = accept_i && (req_i.operation == OP_TICK) && !idle;
   assign tone       = (state_ff == ST_HIGH) || (state_ff == ST_LOW);
   assign gap        = (state_ff == ST_GAP_A) || (state_ff == ST_GAP_B);
   assign pause_zero = (pause_ff == '0);
   // A zero note length acts as one sample.
   assign seg_len    = gap ? pause_ff : ((note_ff == '0) ? LEN_W'(1) : note_ff);
   assign seg_end    = ({1'b0, count_ff} + (LEN_W+1)'(1)) >= {1'b0, seg_len};
   assign nib        = (state_ff == ST_LOW) ? held_ff[3:0] : held_ff[7:4];
   assign row_inc    = ROW_INC[NIB_ROW[nib]];
   assign col_inc    = COL_INC[NIB_COL[nib]];

   // Next segment on a load or at a segment end, skipping gaps of zero length.
   always_comb begin
      state_in = state_ff;
      if (load) begin
         state_in = ST_HIGH;
      end else if (tick_busy && seg_end) begin
         unique case (state_ff)
            ST_HIGH:  state_in = pause_zero ? ST_LOW : ST_GAP_A;
            ST_GAP_A: state_in = ST_LOW;
            ST_LOW:   state_in = pause_zero ? ST_IDLE : ST_GAP_B;
            ST_GAP_B: state_in = ST_IDLE;
            ST_IDLE:  state_in = ST_IDLE;
            default:  state_in = ST_IDLE;
         endcase
      end
   end

   always_comb begin
      held_in      = held_ff;
      count_in     = count_ff;
      row_phase_in = row_phase_ff;
      col_phase_in = col_phase_ff;
      if (load) begin
         held_in      = req_i.character;
         count_in     = '0;
         row_phase_in = '0;
         col_phase_in = '0;
      end else if (tick_busy) begin
         if (seg_end) begin
            count_in     = '0;
            row_phase_in = '0;
            col_phase_in = '0;
         end else begin
            count_in = LEN_W'(count_ff + 1'b1);
            if (tone) begin
               row_phase_in = row_phase_ff + row_inc;
               col_phase_in = col_phase_ff + col_inc;
            end
         end
      end
   end

   always_comb begin
      ctl_o.fire = tick_busy;
      ctl_o.tone = tone;
      ctl_o.last = tick_busy && seg_end && (state_in == ST_IDLE);
   end

   assign amp_o     = amp_ff;
   assign row_idx_o = row_phase_ff[PHASE_BITS-1 -: TABLE_ADDR_BITS];
   assign col_idx_o = col_phase_ff[PHASE_BITS-1 -: TABLE_ADDR_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         note_ff  <= NOTE_RESET;
         pause_ff <= PAUSE_RESET;
         amp_ff   <= AMP_RESET;
      end else if (csr_wen_i) begin
         unique case (csr_addr_i)
            CSR_NOTE:  note_ff  <= csr_wdata_i[LEN_W-1:0];
            CSR_PAUSE: pause_ff <= csr_wdata_i[LEN_W-1:0];
            CSR_AMP:   amp_ff   <= csr_wdata_i[AMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         count_ff     <= '0;
         row_phase_ff <= '0;
         col_phase_ff <= '0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         count_ff     <= count_in;
         row_phase_ff <= row_phase_in;
         col_phase_ff <= col_phase_in;
      end
   end

`ifndef ASSERT_OFF
   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      ctl_o.fire && ctl_o.last |=> state_ff == ST_IDLE)
      else $error("sequence end did not return to idle");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> count_ff == '0 && row_phase_ff == '0 && col_phase_ff == '0)
      else $error("idle with stale counter or phase");

   a_gap_phase_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GAP_A || state_ff == ST_GAP_B) |->
         row_phase_ff == '0 && col_phase_ff == '0)
      else $error("phase moved during a gap");
`endif

endmodule

// File: sv/nibdtmf_cos.sv
// Cosine lookup: quarter-wave table, quadrant fold and sum of the row and column tones.
module nibdtmf_cos
   import nibdtmf_pkg::*;
#(
   parameter int unsigned TABLE_ADDR_BITS = 10
) (
   input  logic [TABLE_ADDR_BITS-1:0] row_idx_i,
   input  logic [TABLE_ADDR_BITS-1:0] col_idx_i,
   output logic signed [SUM_W-1:0]    sum_o
);

   localparam int unsigned QUARTER_BITS = TABLE_ADDR_BITS - 2;
   localparam int unsigned QIDX_W       = TABLE_ADDR_BITS - 1;
   localparam int unsigned QDEPTH       = (1 << QUARTER_BITS) + 1;
   localparam logic [QIDX_W-1:0] QUARTER = {1'b1, {QUARTER_BITS{1'b0}}};

   logic [MAG_W-1:0]              qtab [QDEPTH];
   logic [TABLE_ADDR_BITS-1:0]    idx  [2];
   logic signed [SAMPLE_W-1:0]    val  [2];

   for (genvar i = 0; i < QDEPTH; i++) begin : g_tab
      assign qtab[i] = quarter_mag(i, TABLE_ADDR_BITS);
   end

   assign idx[0] = row_idx_i;
   assign idx[1] = col_idx_i;

   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic [1:0]              quad;
      logic [QUARTER_BITS-1:0] low;
      logic [QIDX_W-1:0]       qidx;
      logic [MAG_W-1:0]        mag;

      assign quad = idx[ln][TABLE_ADDR_BITS-1 -: 2];
      assign low  = idx[ln][QUARTER_BITS-1:0];
      // Mirror in the second and fourth quadrants, negate in the middle two.
      assign qidx = quad[0] ? (QUARTER - {1'b0, low}) : {1'b0, low};
      assign mag  = qtab[qidx];
      assign val[ln] = (quad[1] ^ quad[0]) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   assign sum_o = SUM_W'(val[0]) + SUM_W'(val[1]);

endmodule

// File: sv/nibdtmf_out.sv
// Sample pipeline: sum register, amplitude scaling and result register with handshake.
module nibdtmf_out
   import nibdtmf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  seq_ctl_type             ctl_i,
   input  logic signed [SUM_W-1:0] sum_i,
   input  logic [AMP_W-1:0]        amp_i,
   output logic                    ready_o,
   output logic                    rsp_valid_o,
   input  logic                    rsp_stall_i,
   output rsp_type                 rsp_payload_o
);

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [SUM_W-1:0]  s1_sum_ff,   s1_sum_in;
   logic [AMP_W-1:0]         s1_amp_ff,   s1_amp_in;
   logic                     s1_last_ff,  s1_last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff,       rsp_in;

   logic                     out_ready;
   logic                     s1_ready;
   logic signed [PROD_W-1:0] prod;

   assign out_ready = !rsp_valid_ff || !rsp_stall_i;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign ready_o   = s1_ready;

   assign prod = $signed({1'b0, s1_amp_ff}) * s1_sum_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_sum_in   = s1_sum_ff;
      s1_amp_in   = s1_amp_ff;
      s1_last_in  = s1_last_ff;
      if (s1_ready) begin
         s1_valid_in = ctl_i.fire;
         if (ctl_i.fire) begin
            // Gaps are silent: force the sum to zero.
            s1_sum_in  = ctl_i.tone ? sum_i : '0;
            s1_amp_in  = amp_i;
            s1_last_in = ctl_i.last;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_ready) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            // Arithmetic shift right by 15; the product always fits 16 bits after it.
            rsp_in.sample = prod[30:15];
            rsp_in.last   = s1_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sum_ff  <= s1_sum_in;
      s1_amp_ff  <= s1_amp_in;
      s1_last_ff <= s1_last_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid_o   = rsp_valid_ff;
   assign rsp_payload_o = rsp_ff;

`ifndef ASSERT_OFF
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_ready |=> s1_valid_ff && $stable(s1_sum_ff) && $stable(s1_last_ff))
      else $error("pending sum lost while output stalled");

   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_ready |=> rsp_valid_ff && rsp_ff.last == $past(s1_last_ff))
      else $error("pending sum not moved to output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall_i |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result changed");
`endif

endmodule

// File: sv/ascii_nibble_dtmf_generator.sv
// Top level of the ASCII nibble DTMF generator.
//
//   port group  dir  handshake             payload
//   req_*       in   req_valid/req_stall   req_type: operation, character
//   rsp_*       out  rsp_valid/rsp_stall   rsp_type: sample, last
//   csr_*       in   csr_wen               csr_addr, csr_wdata
//
// One item is taken per cycle while req_stall is low; a tick while busy yields its sample
// through the sum register and the result register.
// Load and idle ticks change state only and give no result.
// Reset is synchronous and returns the sequencer to idle with registers at defaults.
// req_stall rises only when both pipeline registers hold items and rsp_stall is high.
module ascii_nibble_dtmf_generator
   import nibdtmf_pkg::*;
#(
   parameter int unsigned PHASE_BITS      = 24,
   parameter int unsigned TABLE_ADDR_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                       ready;
   logic                       accept;
   logic [AMP_W-1:0]           amp;
   logic [TABLE_ADDR_BITS-1:0] row_idx;
   logic [TABLE_ADDR_BITS-1:0] col_idx;
   seq_ctl_type                ctl;
   logic signed [SUM_W-1:0]    sum;

   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   nibdtmf_seq #(
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wen_i   (csr_wen),
      .csr_addr_i  (csr_addr),
      .csr_wdata_i (csr_wdata),
      .accept_i    (accept),
      .req_i       (req_payload),
      .amp_o       (amp),
      .row_idx_o   (row_idx),
      .col_idx_o   (col_idx),
      .ctl_o       (ctl)
   );

   nibdtmf_cos #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_cos (
      .row_idx_i (row_idx),
      .col_idx_i (col_idx),
      .sum_o     (sum)
   );

   nibdtmf_out u_out (
      .clock         (clock),
      .reset         (reset),
      .ctl_i         (ctl),
      .sum_i         (sum),
      .amp_i         (amp),
      .ready_o       (ready),
      .rsp_valid_o   (rsp_valid),
      .rsp_stall_i   (rsp_stall),
      .rsp_payload_o (rsp_payload)
   );

endmodule

// File: tb/sv/ascii_nibble_dtmf_generator_tb.sv
// Self-checking testbench for the ASCII nibble DTMF generator with a tone predictor.
module ascii_nibble_dtmf_generator_tb;
   import nibdtmf_pkg::*;

   localparam int unsigned HALF_PERIOD   = 10;
   localparam int unsigned LUT_BITS      = 10;
   localparam int unsigned LUT_SIZE      = 1 << LUT_BITS;
   localparam int unsigned PH_BITS       = 24;
   localparam longint unsigned PI_FIX    = 64'd3373259426;
   localparam longint unsigned ONE_FIX   = 64'd1 << 30;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned IDLE_PCT      = 16;
   localparam int unsigned HOLD_CYCLES   = 150;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASE_ITEMS   = 230;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   // Keypad frequencies per nibble; E is star and F is hash.
   localparam int unsigned TONE_ROW_HZ [16] = '{941, 697, 697, 697, 770, 770, 770, 852,
                                              852, 852, 697, 770, 852, 941, 941, 941};
   localparam int unsigned TONE_COL_HZ [16] = '{1336, 1209, 1336, 1477, 1209, 1336, 1477,
                                              1209, 1336, 1477, 1633, 1633, 1633, 1633,
                                              1209, 1477};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_wen     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   ascii_nibble_dtmf_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wen     (csr_wen),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Predictor state and register shadow
   int                 cos_lut [LUT_SIZE];
   int unsigned        cfg_note  = NOTE_RESET;
   int unsigned        cfg_pause = PAUSE_RESET;
   int unsigned        cfg_amp   = AMP_RESET;
   logic [CHAR_W-1:0]  sq_char;
   int unsigned        sq_seg;
   int unsigned        sq_count;
   logic [PH_BITS-1:0] sq_row_ph;
   logic [PH_BITS-1:0] sq_col_ph;
   bit                 sq_busy;

   req_type     stim_q [$];
   rsp_type     pending_samples [$];
   int unsigned total_pushed = 0;
   int unsigned n_accepted   = 0;
   int unsigned n_loads      = 0;
   int unsigned n_ticks      = 0;
   int unsigned n_checked    = 0;
   int unsigned n_final      = 0;
   int unsigned n_errors     = 0;
   int unsigned cycles       = 0;
   bit          quiet        = 1'b0;
   int unsigned hold_asked   = 0;
   int unsigned hold_served  = 0;
   int unsigned hold_left    = 0;
   rsp_type     want;
   rsp_type     got;

   // Cosine in Q30 on [0, pi/2], ten Taylor terms.
   function automatic longint cos_fix(input longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      x2   = (x * x) >> 30;
      term = ONE_FIX;
      acc  = longint'(ONE_FIX);
      for (int n = 1; n <= 10; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
         if (n % 2) acc -= longint'(term);
         else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_FIX)) acc = longint'(ONE_FIX);
      return acc;
   endfunction

   function automatic int lut_entry(input int unsigned m, input bit neg);
      longint unsigned x;
      longint          mag;
      x   = (64'd2 * PI_FIX * longint'(m)) >> LUT_BITS;
      mag = (cos_fix(x) * 32767 + (longint'(1) << 29)) >>> 30;
      return neg ? -int'(mag) : int'(mag);
   endfunction

   function automatic logic [PH_BITS-1:0] phase_step(input int unsigned hz);
      longint unsigned num;
      num = (longint'(hz) << PH_BITS) + TONE_FS_HZ / 2;
      return PH_BITS'(num / TONE_FS_HZ);
   endfunction

   function automatic int unsigned seg_len(input int unsigned s);
      if (s & 1) return cfg_pause;
      return (cfg_note == 0) ? 1 : cfg_note;
   endfunction

   // Advance the tone sequencer by one accepted item; queue the sample it yields.
   task automatic advance_sequencer(input req_type it);
      logic [3:0]           nib;
      int                   tone_sum;
      longint               prod;
      logic [SAMPLE_W-1:0]  value;
      logic                 fin;
      rsp_type              res;
      value = '0;
      fin   = 1'b0;
      if (it.operation == OP_LOAD) begin
         n_loads++;
         if (!sq_busy) begin
            sq_char   = it.character;
            sq_seg    = 0;
            sq_count  = 0;
            sq_row_ph = '0;
            sq_col_ph = '0;
            sq_busy   = 1'b1;
         end
      end else begin
         n_ticks++;
         if (sq_busy) begin
            if ((sq_seg & 1) == 0) begin
               nib      = (sq_seg == 0) ? sq_char[7:4] : sq_char[3:0];
               tone_sum = cos_lut[sq_row_ph[PH_BITS-1 -: LUT_BITS]] +
                          cos_lut[sq_col_ph[PH_BITS-1 -: LUT_BITS]];
               prod      = longint'(cfg_amp) * longint'(tone_sum);
               value     = SAMPLE_W'(prod >>> 15);
               sq_row_ph = sq_row_ph + phase_step(TONE_ROW_HZ[nib]);
               sq_col_ph = sq_col_ph + phase_step(TONE_COL_HZ[nib]);
            end
            if (sq_count + 1 >= seg_len(sq_seg)) begin
               sq_count  = 0;
               sq_row_ph = '0;
               sq_col_ph = '0;
               sq_seg++;
               while (sq_seg < 4 && seg_len(sq_seg) == 0) sq_seg++;
               if (sq_seg >= 4) begin
                  sq_seg  = 0;
                  sq_busy = 1'b0;
                  fin     = 1'b1;
               end
            end else begin
               sq_count = (sq_count + 1) & 16'hFFFF;
            end
            res.sample = value;
            res.last   = fin;
            pending_samples.push_back(res);
         end
      end
   endtask

   // Driver: offer queued items, hold while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_sequencer(req_payload);
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (stim_q.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid   <= 1'b1;
               req_payload <= stim_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each sample with the oldest prediction, drive rsp_stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (pending_samples.size() == 0) begin
               $error("unexpected sample %0d last %0b", $signed(got.sample), got.last);
               n_errors++;
            end else begin
               want = pending_samples.pop_front();
               n_checked++;
               if (want.last) n_final++;
               if (got.sample !== want.sample) begin
                  $error("sample: expected %0d, got %0d",
                         $signed(want.sample), $signed(got.sample));
                  n_errors++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, got.last);
                  n_errors++;
               end
            end
         end
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic void push_item(input op_type op, input logic [CHAR_W-1:0] ch);
      req_type it;
      it.operation = op;
      it.character = ch;
      stim_q.push_back(it);
      total_pushed++;
   endfunction

   // Wait until every item is taken and every sample is back, then let loads finish.
   task automatic settle();
      do @(posedge clock);
      while (n_accepted != total_pushed || pending_samples.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_NOTE:  cfg_note  = val;
         CSR_PAUSE: cfg_pause = val;
         CSR_AMP:   cfg_amp   = val[AMP_W-1:0];
         default:   ;
      endcase
   endtask

   task automatic push_ticks(input int unsigned n);
      repeat (n) push_item(OP_TICK, CHAR_W'($urandom_range(0, 255)));
   endtask

   // One character's load and tick run, sometimes cut short or mixed with noise.
   task automatic queue_character();
      int unsigned n;
      push_item(OP_LOAD, CHAR_W'($urandom_range(0, 255)));
      n = 2 * ((cfg_note == 0) ? 1 : cfg_note) + 2 * cfg_pause;
      if ($urandom_range(0, 99) < 5) n = $urandom_range(1, n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 3) push_item(OP_LOAD, CHAR_W'($urandom_range(0, 255)));
         push_ticks(1);
      end
      if ($urandom_range(0, 99) < 20) push_ticks($urandom_range(1, 3));
   endtask

   task automatic run_phase(input int unsigned note, input int unsigned pause,
                            input int unsigned amp, input bit hold);
      int unsigned start;
      write_reg(CSR_NOTE, CSR_DATA_W'(note));
      write_reg(CSR_PAUSE, CSR_DATA_W'(pause));
      write_reg(CSR_AMP, CSR_DATA_W'(amp));
      start = total_pushed;
      while (total_pushed - start < PHASE_ITEMS) queue_character();
      if (hold) hold_asked++;
      settle();
   endtask

   initial begin
      for (int k = 0; k < LUT_SIZE; k++) begin
         if (k <= LUT_SIZE / 4) cos_lut[k] = lut_entry(k, 1'b0);
         else if (k <= LUT_SIZE / 2) cos_lut[k] = lut_entry(LUT_SIZE / 2 - k, 1'b1);
         else if (k <= 3 * LUT_SIZE / 4) cos_lut[k] = lut_entry(k - LUT_SIZE / 2, 1'b1);
         else cos_lut[k] = lut_entry(LUT_SIZE - k, 1'b0);
      end
      sq_char   = '0;
      sq_seg    = 0;
      sq_count  = 0;
      sq_row_ph = '0;
      sq_col_ph = '0;
      sq_busy   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Idle tick, then a load at reset lengths with a second load ignored while busy.
      push_item(OP_TICK, 8'hA5);
      push_item(OP_LOAD, 8'h3E);
      push_item(OP_LOAD, 8'h11);
      push_ticks(3);
      settle();
      // Longest lengths and full amplitude, then shorten the tone mid-segment.
      write_reg(CSR_NOTE, 16'hFFFF);
      write_reg(CSR_PAUSE, 16'hFFFF);
      write_reg(CSR_AMP, 16'd16383);
      push_ticks(2);
      settle();
      write_reg(CSR_NOTE, 16'd2);
      push_ticks(2);
      settle();
      // Drop the pause mid-gap: gap ends, final gap is skipped.
      write_reg(CSR_PAUSE, 16'd0);
      push_ticks(3);
      settle();
      // Zero note length acts as one sample, zero amplitude, spare index ignored.
      write_reg(CSR_NOTE, 16'd0);
      write_reg(CSR_PAUSE, 16'd1);
      write_reg(CSR_AMP, 16'd0);
      write_reg(CSR_SPARE, 16'hBEEF);
      push_item(OP_LOAD, 8'hFF);
      push_ticks(4);
      settle();
      write_reg(CSR_NOTE, 16'd1);
      write_reg(CSR_PAUSE, 16'd0);
      write_reg(CSR_AMP, 16'd16383);
      push_item(OP_LOAD, 8'h00);
      push_ticks(3);
      settle();

      run_phase(3, 2, $urandom_range(0, 16383), 1'b0);
      run_phase(1, 0, 16383, 1'b0);
      run_phase(5, 1, $urandom_range(0, 16383), 1'b1);
      quiet = 1'b1;
      run_phase(40, 3, $urandom_range(0, 16383), 1'b0);
      quiet = 1'b0;
      run_phase(2, 4, $urandom_range(0, 63), 1'b0);
      run_phase(0, 2, $urandom_range(0, 16383), 1'b0);
      run_phase($urandom_range(1, 12), $urandom_range(0, 5), $urandom_range(0, 16383), 1'b0);

      settle();
      repeat (20) @(posedge clock);
      $display("Ran %0d items: %0d loads and %0d ticks over directed corners and seven phases.",
               n_accepted, n_loads, n_ticks);
      $display("Checked %0d samples, %0d of them closing a character.", n_checked, n_final);
      if (n_errors == 0 && pending_samples.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
